>>> hdl/rdpr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and codes of the radio data packet reassembler.
package rdpr_pkg;

   localparam int BUFFER_BYTES = 1024;
   localparam int IDX_W        = $clog2(BUFFER_BYTES + 1);
   localparam int HDR_BYTES    = 10;
   localparam int HDR_IDX_W    = $clog2(HDR_BYTES);
   localparam int CAP_BYTES    = 12;
   localparam int CAP_IDX_W    = $clog2(CAP_BYTES);
   localparam int CAP_FIRST    = 12;
   localparam int POS_W        = 5;
   localparam int LEN_W        = 5;
   localparam int BLK_W        = 7;
   localparam int PAD_W        = 5;
   localparam int PLEN_W       = 11;
   localparam int SERIAL_W     = 8;

   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam logic [1:0]       CONF_SKIP = 2'd2;

   localparam logic [3:0] FMT_UDT           = 4'd0;
   localparam logic [3:0] FMT_RESPONSE      = 4'd1;
   localparam logic [3:0] FMT_UNCONF        = 4'd2;
   localparam logic [3:0] FMT_CONF          = 4'd3;
   localparam logic [3:0] FMT_SHORT_DEFINED = 4'd13;
   localparam logic [3:0] FMT_SHORT_RAW     = 4'd14;
   localparam logic [3:0] FMT_PROPRIETARY   = 4'd15;

   localparam logic [4:0] SAP_NONE = 5'd16;

   typedef enum logic [2:0] {
      KIND_HEADER       = 3'd0,
      KIND_COMPLETE     = 3'd1,
      KIND_SPURIOUS     = 3'd2,
      KIND_OUT_OF_ORDER = 3'd3,
      KIND_DROPPED      = 3'd4
   } kind_type;

   typedef logic [HDR_BYTES-1:0][7:0] hdr_bytes_type;
   typedef logic [CAP_BYTES-1:0][7:0] cap_bytes_type;

   typedef struct packed {
      logic [3:0]       format_code;
      logic [4:0]       service_point;
      logic             group_call;
      logic             answer_requested;
      logic [23:0]      source_address;
      logic [23:0]      destination_address;
      logic [BLK_W-1:0] blocks;
      logic [PAD_W-1:0] pad;
   } hdr_type;

   typedef struct packed {
      kind_type          kind;
      logic [3:0]        format_code;
      logic [4:0]        service_point;
      logic              group_call;
      logic              answer_requested;
      logic [23:0]       source_address;
      logic [23:0]       destination_address;
      logic [BLK_W-1:0]  blocks_expected;
      logic [PLEN_W-1:0] payload_length;
      logic [31:0]       ip_source;
      logic [31:0]       ip_destination;
      logic [31:0]       port_pair;
   } rsp_type;

endpackage

>>> hdl/rdpr_if.sv
`timescale 1ns / 1ps
// Valid/ready channels for frame bytes in and reassembly results out.
interface rdpr_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] frame_byte;
   logic       frame_end;
   logic [4:0] frame_length;

   modport source (output valid, op, frame_byte, frame_end, frame_length, input ready);
   modport sink   (input valid, op, frame_byte, frame_end, frame_length, output ready);
endinterface

interface rdpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [3:0]  format_code;
   logic [4:0]  service_point;
   logic        group_call;
   logic        answer_requested;
   logic [23:0] source_address;
   logic [23:0] destination_address;
   logic [6:0]  blocks_expected;
   logic [10:0] payload_length;
   logic [31:0] ip_source;
   logic [31:0] ip_destination;
   logic [31:0] port_pair;

   modport source (output valid, kind, format_code, service_point, group_call,
                   answer_requested, source_address, destination_address,
                   blocks_expected, payload_length, ip_source, ip_destination,
                   port_pair, input ready);
   modport sink   (input valid, kind, format_code, service_point, group_call,
                   answer_requested, source_address, destination_address,
                   blocks_expected, payload_length, ip_source, ip_destination,
                   port_pair, output ready);
endinterface

>>> hdl/radio_data_packet_reassembler.sv
`timescale 1ns / 1ps
// Radio data packet reassembler top level: byte stage, reassembly state, result register.
// A byte taken on req is held in the byte stage; its result is then registered in the result register for rsp.
// Throughput: one byte per cycle; the byte stage stalls only while the result register is full
// and not taken.
// Reset: synchronous, clears the header bytes, IP capture, counters, format and channel state.
module radio_data_packet_reassembler (
   input  logic              clock,
   input  logic              reset,
   rdpr_req_if.sink          req_chan,
   rdpr_rsp_if.source        rsp_chan
);

   localparam int IDX_W = rdpr_pkg::IDX_W;
   localparam int POS_W = rdpr_pkg::POS_W;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_op_ff;
   logic [7:0]                    s1_byte_ff;
   logic                          s1_end_ff;
   logic [rdpr_pkg::LEN_W-1:0]    s1_len_ff;

   rdpr_pkg::hdr_bytes_type       hdr_ff, hdr_in;
   rdpr_pkg::cap_bytes_type       cap_ff, cap_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [rdpr_pkg::BLK_W-1:0]    blocks_ff, blocks_in;
   logic [rdpr_pkg::PAD_W-1:0]    pad_ff, pad_in;
   logic [3:0]                    fmt_ff, fmt_in;
   logic [IDX_W-1:0]              wi_ff, wi_in;
   logic [rdpr_pkg::SERIAL_W-1:0] serial_ff, serial_in;
   logic                          discard_ff, discard_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   rdpr_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          has_result;

   logic                          req_xfer;
   logic                          out_free;
   logic                          advance;

   rdpr_pkg::hdr_type             hdr;
   logic                          confirmed;
   logic [1:0]                    skip;
   logic [rdpr_pkg::LEN_W-1:0]    stored;
   logic [IDX_W:0]                sum;
   logic                          fits;
   logic                          first;
   logic                          spurious;
   logic                          out_of_order;
   logic                          take;
   logic                          discard_eff;
   logic [rdpr_pkg::BLK_W-1:0]    blocks_after;
   logic [IDX_W:0]                cap_pos;
   logic [IDX_W:0]                cap_off;
   logic                          completion;
   logic [IDX_W-1:0]              wi_after;
   logic [IDX_W-1:0]              plen;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_xfer) begin
         s1_op_ff   <= req_chan.op;
         s1_byte_ff <= req_chan.frame_byte;
         s1_end_ff  <= req_chan.frame_end;
         s1_len_ff  <= req_chan.frame_length;
      end
   end

   always_comb begin
      hdr_in = hdr_ff;
      if (!s1_op_ff && pos_ff < POS_W'(rdpr_pkg::HDR_BYTES)) begin
         hdr_in[pos_ff[rdpr_pkg::HDR_IDX_W-1:0]] = s1_byte_ff;
      end
   end

   rdpr_hdr_dec u_hdr_dec (
      .hdr_bytes (hdr_in),
      .hdr       (hdr)
   );

   always_comb begin
      confirmed    = fmt_ff != rdpr_pkg::FMT_UNCONF && fmt_ff != rdpr_pkg::FMT_UDT;
      skip         = (fmt_ff == rdpr_pkg::FMT_UNCONF) ? 2'd0 : rdpr_pkg::CONF_SKIP;
      if (fmt_ff == rdpr_pkg::FMT_UDT) begin
         stored = '0;
      end else if (s1_len_ff > rdpr_pkg::LEN_W'(skip)) begin
         stored = s1_len_ff - rdpr_pkg::LEN_W'(skip);
      end else begin
         stored = '0;
      end
      sum          = (IDX_W + 1)'(wi_ff) + (IDX_W + 1)'(stored);
      fits         = sum <= (IDX_W + 1)'(rdpr_pkg::BUFFER_BYTES);
      first        = pos_ff == '0;
      spurious     = first && blocks_ff == '0;
      out_of_order = first && !spurious && confirmed
                     && {1'b0, s1_byte_ff[7:1]} != serial_ff;
      take         = first && !spurious && !out_of_order;
      discard_eff  = first ? (spurious || out_of_order) : discard_ff;
      blocks_after = take ? blocks_ff - 1'b1 : blocks_ff;
      cap_pos      = (IDX_W + 1)'(wi_ff) + (IDX_W + 1)'(pos_ff) - (IDX_W + 1)'(skip);
      cap_off      = cap_pos - (IDX_W + 1)'(rdpr_pkg::CAP_FIRST);
      completion   = s1_end_ff && !discard_eff && blocks_after == '0;
      wi_after     = (s1_end_ff && !discard_eff && fits) ? sum[IDX_W-1:0] : wi_ff;
      plen         = (wi_after > IDX_W'(pad_ff)) ? wi_after - IDX_W'(pad_ff) : '0;

      cap_in = cap_ff;
      if (s1_op_ff && !discard_eff && fmt_ff != rdpr_pkg::FMT_UDT
          && pos_ff >= POS_W'(skip) && fits
          && cap_pos >= (IDX_W + 1)'(rdpr_pkg::CAP_FIRST)
          && cap_pos < (IDX_W + 1)'(rdpr_pkg::CAP_FIRST + rdpr_pkg::CAP_BYTES)) begin
         cap_in[cap_off[rdpr_pkg::CAP_IDX_W-1:0]] = s1_byte_ff;
      end
   end

   always_comb begin
      blocks_in  = blocks_ff;
      pad_in     = pad_ff;
      fmt_in     = fmt_ff;
      wi_in      = wi_ff;
      serial_in  = serial_ff;
      discard_in = discard_ff;
      if (!s1_op_ff) begin
         if (s1_end_ff) begin
            blocks_in  = hdr.blocks;
            pad_in     = hdr.pad;
            fmt_in     = hdr.format_code;
            wi_in      = '0;
            serial_in  = '0;
            discard_in = 1'b0;
         end
      end else begin
         blocks_in  = blocks_after;
         wi_in      = wi_after;
         serial_in  = (take && confirmed) ? serial_ff + 1'b1 : serial_ff;
         discard_in = s1_end_ff ? 1'b0 : discard_eff;
      end
      if (s1_end_ff) begin
         pos_in = '0;
      end else if (pos_ff < rdpr_pkg::POS_MAX) begin
         pos_in = pos_ff + 1'b1;
      end else begin
         pos_in = pos_ff;
      end
   end

   always_comb begin
      rsp_in     = '0;
      has_result = 1'b0;
      if (!s1_op_ff) begin
         has_result                 = s1_end_ff;
         rsp_in.kind                = rdpr_pkg::KIND_HEADER;
         rsp_in.format_code         = hdr.format_code;
         rsp_in.service_point       = hdr.service_point;
         rsp_in.group_call          = hdr.group_call;
         rsp_in.answer_requested    = hdr.answer_requested;
         rsp_in.source_address      = hdr.source_address;
         rsp_in.destination_address = hdr.destination_address;
         rsp_in.blocks_expected     = hdr.blocks;
      end else if (completion) begin
         has_result            = 1'b1;
         rsp_in.kind           = rdpr_pkg::KIND_COMPLETE;
         rsp_in.payload_length = rdpr_pkg::PLEN_W'(plen);
         rsp_in.ip_source      = {cap_in[0], cap_in[1], cap_in[2], cap_in[3]};
         rsp_in.ip_destination = {cap_in[4], cap_in[5], cap_in[6], cap_in[7]};
         rsp_in.port_pair      = {cap_in[8], cap_in[9], cap_in[10], cap_in[11]};
      end else if (spurious) begin
         has_result  = 1'b1;
         rsp_in.kind = rdpr_pkg::KIND_SPURIOUS;
      end else if (out_of_order) begin
         has_result  = 1'b1;
         rsp_in.kind = rdpr_pkg::KIND_OUT_OF_ORDER;
      end else if (take && !fits) begin
         has_result  = 1'b1;
         rsp_in.kind = rdpr_pkg::KIND_DROPPED;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = has_result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff       <= '0;
         cap_ff       <= '0;
         pos_ff       <= '0;
         blocks_ff    <= '0;
         pad_ff       <= '0;
         fmt_ff       <= '0;
         wi_ff        <= '0;
         serial_ff    <= '0;
         discard_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            hdr_ff     <= hdr_in;
            cap_ff     <= cap_in;
            pos_ff     <= pos_in;
            blocks_ff  <= blocks_in;
            pad_ff     <= pad_in;
            fmt_ff     <= fmt_in;
            wi_ff      <= wi_in;
            serial_ff  <= serial_in;
            discard_ff <= discard_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.kind                = rsp_ff.kind;
   assign rsp_chan.format_code         = rsp_ff.format_code;
   assign rsp_chan.service_point       = rsp_ff.service_point;
   assign rsp_chan.group_call          = rsp_ff.group_call;
   assign rsp_chan.answer_requested    = rsp_ff.answer_requested;
   assign rsp_chan.source_address      = rsp_ff.source_address;
   assign rsp_chan.destination_address = rsp_ff.destination_address;
   assign rsp_chan.blocks_expected     = rsp_ff.blocks_expected;
   assign rsp_chan.payload_length      = rsp_ff.payload_length;
   assign rsp_chan.ip_source           = rsp_ff.ip_source;
   assign rsp_chan.ip_destination      = rsp_ff.ip_destination;
   assign rsp_chan.port_pair           = rsp_ff.port_pair;

endmodule

>>> hdl/rdpr_hdr_dec.sv
`timescale 1ns / 1ps
// Data header field decoder: format, SAP, flags, addresses, blocks and pad.
module rdpr_hdr_dec (
   input  rdpr_pkg::hdr_bytes_type hdr_bytes,
   output rdpr_pkg::hdr_type       hdr
);

   logic [7:0] b0;
   logic [7:0] b1;

   assign b0 = hdr_bytes[0];
   assign b1 = hdr_bytes[1];

   always_comb begin
      hdr                     = '0;
      hdr.format_code         = b0[3:0];
      hdr.group_call          = b0[7];
      hdr.answer_requested    = b0[6];
      hdr.destination_address = {hdr_bytes[2], hdr_bytes[3], hdr_bytes[4]};
      hdr.source_address      = {hdr_bytes[5], hdr_bytes[6], hdr_bytes[7]};
      unique case (b0[3:0])
         rdpr_pkg::FMT_UDT: begin
            hdr.service_point = {1'b0, b1[7:4]};
         end
         rdpr_pkg::FMT_RESPONSE, rdpr_pkg::FMT_UNCONF, rdpr_pkg::FMT_CONF: begin
            hdr.service_point = {1'b0, b1[7:4]};
            hdr.blocks        = hdr_bytes[8][6:0];
            hdr.pad           = {b0[4], b1[3:0]};
         end
         rdpr_pkg::FMT_SHORT_DEFINED: begin
            hdr.service_point = {1'b0, b1[7:4]};
            hdr.blocks        = {1'b0, b0[5:4], b1[3:0]};
         end
         rdpr_pkg::FMT_SHORT_RAW: begin
            hdr.service_point = {1'b0, b1[7:4]};
         end
         rdpr_pkg::FMT_PROPRIETARY: begin
            hdr.service_point = {1'b0, b0[7:4]};
         end
         default: begin
            hdr.service_point = rdpr_pkg::SAP_NONE;
         end
      endcase
   end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the radio data packet reassembler: directed table, random frames.
module tb_top;
   import rdpr_pkg::*;

   localparam int STIM_ITEMS   = 1650;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      bit       op;
      bit [7:0] data;
      bit       last;
      bit [4:0] len;
   } frame_byte_type;

   typedef struct {
      frame_byte_type item;
      bit             typed;
      rsp_type        want;
   } directed_row_type;

   logic clock;
   logic reset;

   rdpr_req_if req_if();
   rdpr_rsp_if rsp_if();

   radio_data_packet_reassembler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   bit [7:0]      hdr_m [HDR_BYTES];
   int unsigned   pos_m;
   bit [7:0]      outstanding_m;
   bit [4:0]      pad_m;
   bit [3:0]      fmt_m;
   int unsigned   widx_m;
   bit [7:0]      serial_m;
   bit            discard_m;
   bit [7:0]      cap_m [CAP_BYTES];

   rsp_type          expected_q [$];
   frame_byte_type   stim_q [$];
   directed_row_type directed_q [$];

   int fail_count;
   int transfers;
   int cycle_count;
   int idle_pct;
   int stall_pct;
   int kind_count [8];
   int idle_by_phase [4]  = '{0, 75, 0, 19};
   int stall_by_phase [4] = '{0, 0, 75, 19};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned skip_len();
      return (fmt_m == FMT_UNCONF) ? 0 : CONF_SKIP;
   endfunction

   function automatic int unsigned stored_len(bit [4:0] len);
      if (fmt_m == FMT_UDT) return 0;
      return (len > skip_len()) ? len - skip_len() : 0;
   endfunction

   function automatic bit fits(bit [4:0] len);
      return widx_m + stored_len(len) <= BUFFER_BYTES;
   endfunction

   function automatic bit confirmed_fmt();
      return fmt_m != FMT_UNCONF && fmt_m != FMT_UDT;
   endfunction

   function automatic rsp_type mk_rsp(kind_type kind, bit [3:0] fmt, bit [4:0] sap, bit grp,
                                      bit ans, bit [23:0] src, bit [23:0] dst, bit [6:0] blk,
                                      bit [10:0] plen);
      rsp_type r;
      r = '0;
      r.kind                = kind;
      r.format_code         = fmt;
      r.service_point       = sap;
      r.group_call          = grp;
      r.answer_requested    = ans;
      r.source_address      = src;
      r.destination_address = dst;
      r.blocks_expected     = blk;
      r.payload_length      = plen;
      return r;
   endfunction

   function automatic bit predict_reassembly(input frame_byte_type it, output rsp_type res);
      bit          hit;
      int unsigned pos;
      int unsigned p;
      bit [3:0]    f;
      bit [6:0]    blk;
      bit [4:0]    pad;
      bit [4:0]    sap;
      hit = 1'b0;
      pos = pos_m;
      res = '0;
      if (!it.op) begin
         if (pos < HDR_BYTES) hdr_m[pos] = it.data;
         if (it.last) begin
            f   = hdr_m[0][3:0];
            blk = '0;
            pad = '0;
            sap = SAP_NONE;
            if (f == FMT_RESPONSE || f == FMT_UNCONF || f == FMT_CONF) begin
               blk = hdr_m[8][6:0];
               pad = {hdr_m[0][4], hdr_m[1][3:0]};
            end else if (f == FMT_SHORT_DEFINED) begin
               blk = {1'b0, hdr_m[0][5:4], hdr_m[1][3:0]};
            end
            if (f <= FMT_CONF || f == FMT_SHORT_DEFINED || f == FMT_SHORT_RAW)
               sap = {1'b0, hdr_m[1][7:4]};
            else if (f == FMT_PROPRIETARY)
               sap = {1'b0, hdr_m[0][7:4]};
            outstanding_m = {1'b0, blk};
            pad_m         = pad;
            fmt_m         = f;
            widx_m        = 0;
            serial_m      = '0;
            discard_m     = 1'b0;
            res = mk_rsp(KIND_HEADER, f, sap, hdr_m[0][7], hdr_m[0][6],
                         {hdr_m[5], hdr_m[6], hdr_m[7]}, {hdr_m[2], hdr_m[3], hdr_m[4]},
                         blk, '0);
            hit = 1'b1;
         end
      end else begin
         if (pos == 0) begin
            discard_m = 1'b0;
            if (outstanding_m == 0) begin
               res.kind  = KIND_SPURIOUS;
               hit       = 1'b1;
               discard_m = 1'b1;
            end else if (confirmed_fmt() && it.data[7:1] != serial_m) begin
               res.kind  = KIND_OUT_OF_ORDER;
               hit       = 1'b1;
               discard_m = 1'b1;
            end else begin
               if (confirmed_fmt()) serial_m++;
               outstanding_m--;
               if (!fits(it.len)) begin
                  res.kind = KIND_DROPPED;
                  hit      = 1'b1;
               end
            end
         end
         if (!discard_m && fmt_m != FMT_UDT && pos >= skip_len() && fits(it.len)) begin
            p = widx_m + pos - skip_len();
            if (p >= CAP_FIRST && p < CAP_FIRST + CAP_BYTES) cap_m[p - CAP_FIRST] = it.data;
         end
         if (it.last && !discard_m) begin
            if (fits(it.len)) widx_m += stored_len(it.len);
            if (outstanding_m == 0) begin
               res = mk_rsp(KIND_COMPLETE, '0, '0, 1'b0, 1'b0, '0, '0, '0,
                            (widx_m > pad_m) ? 11'(widx_m - pad_m) : '0);
               res.ip_source      = {cap_m[0], cap_m[1], cap_m[2], cap_m[3]};
               res.ip_destination = {cap_m[4], cap_m[5], cap_m[6], cap_m[7]};
               res.port_pair      = {cap_m[8], cap_m[9], cap_m[10], cap_m[11]};
               hit = 1'b1;
            end
         end
         if (it.last) discard_m = 1'b0;
      end
      if (it.last) pos_m = 0;
      else if (pos < POS_MAX) pos_m = pos + 1;
      return hit;
   endfunction

   task automatic add_row(bit op, bit [7:0] data, bit last, bit [4:0] len, bit typed,
                          rsp_type want);
      directed_row_type row;
      row.item.op   = op;
      row.item.data = data;
      row.item.last = last;
      row.item.len  = len;
      row.typed     = typed;
      row.want      = want;
      directed_q.push_back(row);
   endtask

   task automatic build_directed();
      rsp_type zero;
      zero = '0;
      add_row(1'b1, 8'h00, 1'b1, 5'd1, 1'b1, mk_rsp(KIND_SPURIOUS, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(1'b0, 8'hD2, 1'b0, 5'd10, 1'b0, zero);
      add_row(1'b0, 8'h35, 1'b0, 5'd10, 1'b0, zero);
      add_row(1'b0, 8'hFF, 1'b0, 5'd10, 1'b0, zero);
      add_row(1'b0, 8'hFF, 1'b0, 5'd10, 1'b0, zero);
      add_row(1'b0, 8'hFF, 1'b0, 5'd10, 1'b0, zero);
      add_row(1'b0, 8'h00, 1'b0, 5'd10, 1'b0, zero);
      add_row(1'b0, 8'h00, 1'b0, 5'd10, 1'b0, zero);
      add_row(1'b0, 8'h01, 1'b0, 5'd10, 1'b0, zero);
      add_row(1'b0, 8'h82, 1'b0, 5'd10, 1'b0, zero);
      add_row(1'b0, 8'h00, 1'b1, 5'd10, 1'b1,
              mk_rsp(KIND_HEADER, FMT_UNCONF, 5'd3, 1, 1, 24'h000001, 24'hFFFFFF, 7'd2, 0));
      add_row(1'b1, 8'hAB, 1'b1, 5'd24, 1'b0, zero);
      add_row(1'b1, 8'h5A, 1'b1, 5'd1, 1'b1, mk_rsp(KIND_COMPLETE, 0, 0, 0, 0, 0, 0, 0, 11'd4));
      add_row(1'b1, 8'hFF, 1'b0, 5'd0, 1'b1, mk_rsp(KIND_SPURIOUS, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(1'b1, 8'h00, 1'b1, 5'd31, 1'b0, zero);
      add_row(1'b0, 8'h03, 1'b1, 5'd1, 1'b1,
              mk_rsp(KIND_HEADER, FMT_CONF, 5'd3, 0, 0, 24'h000001, 24'hFFFFFF, 7'd2, 0));
      add_row(1'b1, 8'h02, 1'b1, 5'd5, 1'b1, mk_rsp(KIND_OUT_OF_ORDER, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(1'b1, 8'h01, 1'b0, 5'd1, 1'b0, zero);
      add_row(1'b1, 8'h00, 1'b1, 5'd1, 1'b0, zero);
      add_row(1'b0, 8'h3D, 1'b1, 5'd1, 1'b1,
              mk_rsp(KIND_HEADER, FMT_SHORT_DEFINED, 5'd3, 0, 0, 24'h000001, 24'hFFFFFF,
                     7'd53, 0));
      add_row(1'b0, 8'hFF, 1'b1, 5'd1, 1'b1,
              mk_rsp(KIND_HEADER, FMT_PROPRIETARY, 5'd15, 1, 1, 24'h000001, 24'hFFFFFF, 0, 0));
      add_row(1'b0, 8'h07, 1'b1, 5'd1, 1'b1,
              mk_rsp(KIND_HEADER, 4'd7, SAP_NONE, 0, 0, 24'h000001, 24'hFFFFFF, 0, 0));
      add_row(1'b0, 8'h00, 1'b1, 5'd1, 1'b1,
              mk_rsp(KIND_HEADER, FMT_UDT, 5'd3, 0, 0, 24'h000001, 24'hFFFFFF, 0, 0));
      add_row(1'b1, 8'h55, 1'b1, 5'd24, 1'b1, mk_rsp(KIND_SPURIOUS, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic push_byte(bit op, bit [7:0] data, bit last, bit [4:0] len);
      frame_byte_type it;
      it.op   = op;
      it.data = data;
      it.last = last;
      it.len  = len;
      stim_q.push_back(it);
   endtask

   function automatic bit [4:0] pick_length(int unsigned n);
      return ($urandom_range(7) == 0) ? 5'($urandom()) : 5'(n);
   endfunction

   task automatic push_block(bit conf, int unsigned ser, int unsigned nb, bit [4:0] len);
      bit [7:0] data;
      for (int i = 0; i < nb; i++) begin
         data = (i == 0 && conf) ? {7'(ser), 1'($urandom())} : 8'($urandom());
         push_byte(1'b1, data, i == nb - 1, len);
      end
   endtask

   task automatic push_header(bit [7:0] b0, bit [7:0] b1, bit [7:0] b8, int unsigned hlen);
      bit [7:0] data;
      for (int i = 0; i < hlen; i++) begin
         data = (i == 0) ? b0 : (i == 1) ? b1 : (i == 8) ? b8 : 8'($urandom());
         push_byte(1'b0, data, i == hlen - 1, pick_length(hlen));
      end
   endtask

   task automatic gen_packet();
      bit [7:0]    b0;
      bit [7:0]    b1;
      bit [7:0]    b8;
      bit [3:0]    f;
      bit          conf;
      int unsigned nblk;
      int unsigned hlen;
      int unsigned ser;
      int unsigned nb;
      case ($urandom_range(9))
         0, 1, 2, 3: f = FMT_UNCONF;
         4, 5, 6:    f = FMT_CONF;
         7:          f = FMT_RESPONSE;
         8:          f = FMT_SHORT_DEFINED;
         default:    f = 4'($urandom());
      endcase
      b0 = {4'($urandom()), f};
      b1 = 8'($urandom());
      b8 = {1'($urandom()), 7'($urandom_range(0, 6))};
      if (f == FMT_SHORT_DEFINED) begin
         b0[5:4] = 2'b00;
         b1[3:0] = 4'($urandom_range(0, 6));
      end
      if (f == FMT_RESPONSE || f == FMT_UNCONF || f == FMT_CONF) nblk = b8[6:0];
      else if (f == FMT_SHORT_DEFINED) nblk = {b0[5:4], b1[3:0]};
      else nblk = 0;
      conf = f != FMT_UNCONF && f != FMT_UDT;
      case ($urandom_range(9))
         8:       hlen = $urandom_range(11, 12);
         9:       hlen = $urandom_range(1, 9);
         default: hlen = HDR_BYTES;
      endcase
      push_header(b0, b1, b8, hlen);
      ser = 0;
      for (int k = 0; k < nblk; k++) begin
         if (conf && $urandom_range(11) == 0) begin
            nb = $urandom_range(1, 24);
            push_block(conf, (ser + $urandom_range(1, 127)) % 128, nb, pick_length(nb));
         end
         nb = $urandom_range(1, 24);
         push_block(conf, ser, nb, pick_length(nb));
         ser++;
      end
      if ($urandom_range(9) == 0) begin
         nb = $urandom_range(1, 24);
         push_block(conf, ser, nb, pick_length(nb));
      end
   endtask

   task automatic gen_big_packet();
      bit [3:0] f;
      f = $urandom_range(1) ? FMT_UNCONF : FMT_CONF;
      push_header({4'($urandom()), f}, 8'($urandom()), {1'($urandom()), 7'h7F}, HDR_BYTES);
      for (int k = 0; k < 127; k++)
         push_block(f == FMT_CONF, k, ($urandom_range(3) == 0) ? 3 : 1,
                    5'($urandom_range(20, 31)));
   endtask

   task automatic gen_noise();
      bit          long_run;
      int unsigned n;
      long_run = ($urandom_range(9) == 0);
      n = long_run ? $urandom_range(32, 40) : $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
         push_byte(1'($urandom()), 8'($urandom()),
                   (i == n - 1) || (!long_run && $urandom_range(2) == 0), 5'($urandom()));
   endtask

   task automatic build_random();
      int unsigned r;
      while (stim_q.size() < STIM_ITEMS) begin
         r = $urandom_range(99);
         if (r < 6) gen_big_packet();
         else if (r < 80) gen_packet();
         else gen_noise();
      end
   endtask

   task automatic drive_byte(input frame_byte_type it, input bit typed, input rsp_type want);
      rsp_type pred;
      bit      has;
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.op           <= it.op;
      req_if.frame_byte   <= it.data;
      req_if.frame_end    <= it.last;
      req_if.frame_length <= it.len;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      transfers++;
      has = predict_reassembly(it, pred);
      if (typed) expected_q.push_back(want);
      else if (has) expected_q.push_back(pred);
      @(negedge clock);
   endtask

   task automatic compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_result();
      rsp_type got;
      rsp_type want;
      got.kind                = kind_type'(rsp_if.kind);
      got.format_code         = rsp_if.format_code;
      got.service_point       = rsp_if.service_point;
      got.group_call          = rsp_if.group_call;
      got.answer_requested    = rsp_if.answer_requested;
      got.source_address      = rsp_if.source_address;
      got.destination_address = rsp_if.destination_address;
      got.blocks_expected     = rsp_if.blocks_expected;
      got.payload_length      = rsp_if.payload_length;
      got.ip_source           = rsp_if.ip_source;
      got.ip_destination      = rsp_if.ip_destination;
      got.port_pair           = rsp_if.port_pair;
      if (expected_q.size() == 0) begin
         $display("%0t ns: unexpected result, expected none, actual kind %0d", $time,
                  got.kind);
         fail_count++;
      end else begin
         want = expected_q.pop_front();
         kind_count[got.kind]++;
         compare_field("kind", want.kind, got.kind);
         compare_field("format_code", want.format_code, got.format_code);
         compare_field("service_point", want.service_point, got.service_point);
         compare_field("group_call", want.group_call, got.group_call);
         compare_field("answer_requested", want.answer_requested, got.answer_requested);
         compare_field("source_address", want.source_address, got.source_address);
         compare_field("destination_address", want.destination_address,
                       got.destination_address);
         compare_field("blocks_expected", want.blocks_expected, got.blocks_expected);
         compare_field("payload_length", want.payload_length, got.payload_length);
         compare_field("ip_source", want.ip_source, got.ip_source);
         compare_field("ip_destination", want.ip_destination, got.ip_destination);
         compare_field("port_pair", want.port_pair, got.port_pair);
      end
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else if (!reset && rsp_if.valid && rsp_if.ready) begin
         check_result();
      end
   end

   initial begin
      int n;
      rsp_type zero;
      zero                = '0;
      clock               = 1'b0;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.op           = 1'b0;
      req_if.frame_byte   = 8'h00;
      req_if.frame_end    = 1'b0;
      req_if.frame_length = 5'd0;
      rsp_if.ready        = 1'b0;
      idle_pct            = 0;
      stall_pct           = 0;
      build_directed();
      build_random();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_q[i])
         drive_byte(directed_q[i].item, directed_q[i].typed, directed_q[i].want);
      n = stim_q.size();
      for (int ph = 0; ph < 4; ph++) begin
         // hold off until every pending result has drained
         req_if.valid <= 1'b0;
         @(negedge clock);
         while (expected_q.size() != 0) @(negedge clock);
         idle_pct  = idle_by_phase[ph];
         stall_pct = stall_by_phase[ph];
         for (int i = ph * n / 4; i < (ph + 1) * n / 4; i++)
            drive_byte(stim_q[i], 1'b0, zero);
      end
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d byte transfers in %0d cycles over four idle/stall mixes; results seen:",
               transfers, cycle_count);
      $display("%0d header, %0d complete, %0d spurious, %0d out of order, %0d dropped",
               kind_count[KIND_HEADER], kind_count[KIND_COMPLETE], kind_count[KIND_SPURIOUS],
               kind_count[KIND_OUT_OF_ORDER], kind_count[KIND_DROPPED]);
      if (fail_count == 0 && expected_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> sim.f
hdl/rdpr_pkg.sv
hdl/rdpr_if.sv
hdl/rdpr_hdr_dec.sv
hdl/radio_data_packet_reassembler.sv
sim/tb_top.sv
